// ----- rtl/bwci_pkg.sv -----
// shared types, constants and saturation helpers for the wall contact impulse unit
package bwci_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FRONT_LAT   = 7;
  localparam int Q_W         = 31;
  localparam int ONEPE_W     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int NUM_W       = ONEPE_W + 32;
  localparam int DEN_W       = (((62 - FRAC_BITS) > 31) ? (62 - FRAC_BITS) : 31) + 1;
  localparam int DIST_W      = (((32 + FRAC_BITS) > 50) ? (32 + FRAC_BITS) : 50) + 2;

  typedef enum logic [1:0] {
    ST_CLEAR     = 2'd0,
    ST_COLLIDE   = 2'd1,
    ST_PENETRATE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_INV_MASS    = 2'd0,
    REG_INV_INERTIA = 2'd1,
    REG_RESTITUTION = 2'd2,
    REG_DEPTH_EPS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] inv_mass;
    logic [30:0] inv_inertia;
    logic [16:0] restitution;
    logic [30:0] depth_eps;
  } cfg_t;

  // classified pair handed from the front end to the queue
  typedef struct packed {
    status_t            status;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] w;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pdn;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } work_t;

  // impulse handed from the divider to the velocity update
  typedef struct packed {
    status_t            status;
    logic               pass;
    logic [Q_W-1:0]     j;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] w;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pdn;
  } imp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [30:0] usat31(input logic [63:0] x);
    logic [30:0] r;
    if (x > 64'h7fffffff) r = 31'h7fffffff;
    else r = x[30:0];
    return r;
  endfunction

endpackage

// ----- rtl/bwci_front.sv -----
// front end: distance, lever arm, normal velocity, classification, impulse operands
module bwci_front import bwci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] ang_vel,
  input  logic signed [17:0] wall_normal_x,
  input  logic signed [17:0] wall_normal_y,
  input  logic signed [31:0] wall_offset,
  input  cfg_t               cfg,
  output logic               out_valid,
  output work_t              out_rec
);

  logic [FRONT_LAT-1:0] vld;

  logic signed [49:0] s1_vxnx, s1_vyny;
  logic signed [31:0] s1_c, s1_ux, s1_uy, s1_w;
  logic signed [32:0] s1_rx, s1_ry;
  logic signed [17:0] s1_nx, s1_ny;

  logic signed [DIST_W-1:0] s2_dist;
  logic signed [50:0] s2_rxny, s2_rynx;
  logic signed [49:0] s2_uxnx, s2_uynx;
  logic signed [31:0] s2_ux, s2_uy, s2_w;
  logic signed [17:0] s2_nx, s2_ny;

  logic signed [51:0] diff;
  logic signed [DIST_W-1:0] s3_dist;
  logic signed [49:0] s3_uxnx, s3_uynx;
  logic signed [31:0] s3_ux, s3_uy, s3_w, s3_pdn;
  logic signed [17:0] s3_nx, s3_ny;

  logic signed [DIST_W-1:0] s4_dist;
  logic signed [49:0] s4_uxnx, s4_uynx;
  logic signed [63:0] s4_wpdn, s4_sq;
  logic signed [31:0] s4_ux, s4_uy, s4_w, s4_pdn;
  logic signed [17:0] s4_nx, s4_ny;

  logic signed [65:0] vn2;
  logic signed [DIST_W-1:0] eps;
  logic signed [31:0] vn;
  logic signed [32:0] neg_vn;
  status_t status_next;

  status_t s5_status;
  logic [31:0] s5_negvn;
  logic [30:0] s5_sq;
  logic signed [31:0] s5_ux, s5_uy, s5_w, s5_pdn;
  logic signed [17:0] s5_nx, s5_ny;

  logic [ONEPE_W-1:0] onepe;
  status_t s6_status;
  logic [NUM_W-1:0] s6_num;
  logic [61:0] s6_isq;
  logic signed [31:0] s6_ux, s6_uy, s6_w, s6_pdn;
  logic signed [17:0] s6_nx, s6_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[FRONT_LAT-1];

  always_ff @(posedge clk) begin
    s1_vxnx <= vertex_x * wall_normal_x;
    s1_vyny <= vertex_y * wall_normal_y;
    s1_rx   <= {vertex_x[31], vertex_x} - {center_x[31], center_x};
    s1_ry   <= {vertex_y[31], vertex_y} - {center_y[31], center_y};
    s1_c    <= wall_offset;
    s1_ux   <= vel_x;
    s1_uy   <= vel_y;
    s1_w    <= ang_vel;
    s1_nx   <= wall_normal_x;
    s1_ny   <= wall_normal_y;
  end

  always_ff @(posedge clk) begin
    s2_dist <= DIST_W'(s1_vxnx) + DIST_W'(s1_vyny) + (DIST_W'(s1_c) <<< FRAC_BITS);
    s2_rxny <= s1_rx * s1_ny;
    s2_rynx <= s1_ry * s1_nx;
    s2_uxnx <= s1_ux * s1_nx;
    s2_uynx <= s1_uy * s1_ny;
    s2_ux   <= s1_ux;
    s2_uy   <= s1_uy;
    s2_w    <= s1_w;
    s2_nx   <= s1_nx;
    s2_ny   <= s1_ny;
  end

  // perp(r) . n
  assign diff = 52'(s2_rxny) - 52'(s2_rynx);

  always_ff @(posedge clk) begin
    s3_pdn  <= sat32(66'(diff >>> FRAC_BITS));
    s3_dist <= s2_dist;
    s3_uxnx <= s2_uxnx;
    s3_uynx <= s2_uynx;
    s3_ux   <= s2_ux;
    s3_uy   <= s2_uy;
    s3_w    <= s2_w;
    s3_nx   <= s2_nx;
    s3_ny   <= s2_ny;
  end

  always_ff @(posedge clk) begin
    s4_wpdn <= s3_w * s3_pdn;
    s4_sq   <= s3_pdn * s3_pdn;
    s4_dist <= s3_dist;
    s4_uxnx <= s3_uxnx;
    s4_uynx <= s3_uynx;
    s4_ux   <= s3_ux;
    s4_uy   <= s3_uy;
    s4_w    <= s3_w;
    s4_pdn  <= s3_pdn;
    s4_nx   <= s3_nx;
    s4_ny   <= s3_ny;
  end

  // classify at full product precision
  always_comb begin
    vn2    = 66'(s4_uxnx) + 66'(s4_uynx) + 66'(s4_wpdn);
    eps    = $signed(DIST_W'(cfg.depth_eps)) <<< FRAC_BITS;
    vn     = sat32(vn2 >>> FRAC_BITS);
    neg_vn = -(33'(vn));
    if (s4_dist < -eps) status_next = ST_PENETRATE;
    else if (s4_dist < eps && vn2[65]) status_next = ST_COLLIDE;
    else status_next = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    s5_status <= status_next;
    s5_negvn  <= neg_vn[31:0];
    s5_sq     <= usat31($unsigned(s4_sq) >> FRAC_BITS);
    s5_ux     <= s4_ux;
    s5_uy     <= s4_uy;
    s5_w      <= s4_w;
    s5_pdn    <= s4_pdn;
    s5_nx     <= s4_nx;
    s5_ny     <= s4_ny;
  end

  assign onepe = ONEPE_W'(1 << FRAC_BITS) + ONEPE_W'(cfg.restitution);

  always_ff @(posedge clk) begin
    s6_num    <= NUM_W'(onepe) * NUM_W'(s5_negvn);
    s6_isq    <= 62'(cfg.inv_inertia) * 62'(s5_sq);
    s6_status <= s5_status;
    s6_ux     <= s5_ux;
    s6_uy     <= s5_uy;
    s6_w      <= s5_w;
    s6_pdn    <= s5_pdn;
    s6_nx     <= s5_nx;
    s6_ny     <= s5_ny;
  end

  always_ff @(posedge clk) begin
    out_rec.den    <= DEN_W'(cfg.inv_mass) + DEN_W'(s6_isq >> FRAC_BITS);
    out_rec.num    <= s6_num;
    out_rec.status <= s6_status;
    out_rec.ux     <= s6_ux;
    out_rec.uy     <= s6_uy;
    out_rec.w      <= s6_w;
    out_rec.pdn    <= s6_pdn;
    out_rec.nx     <= s6_nx;
    out_rec.ny     <= s6_ny;
  end

endmodule

// ----- rtl/bwci_queue.sv -----
// short queue between the front end and the impulse back end
module bwci_queue import bwci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  work_t           push_rec,
  output logic            pop,
  output work_t           pop_rec,
  output logic [QPTR_W:0] count
);

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  // back end never stalls, so it drains whenever something is queued
  assign pop     = (count != '0);
  assign pop_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + (QPTR_W+1)'($past(push)) - (QPTR_W+1)'($past(pop)))
    else $error("queue count out of step");

  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push) |=> count == '0)
    else $error("queue filled without push");
`endif

endmodule

// ----- rtl/bwci_div.sv -----
// pipelined restoring divider for the impulse, one quotient bit per stage
module bwci_div import bwci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  work_t in_rec,
  output logic  out_valid,
  output imp_t  out_imp
);

  localparam int WIDE_W = NUM_W + DEN_W;

  typedef struct packed {
    status_t            status;
    logic               pass;
    logic               sat;
    logic [DEN_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [Q_W-1:0]     numlo;
    logic [Q_W-1:0]     q;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] w;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pdn;
  } dstage_t;

  dstage_t          stg [Q_W+1];
  logic [Q_W:0]     vld;
  logic [WIDE_W-1:0] wide_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Q_W-1:0], in_valid};
    end
  end

  // quotient of 2^31 or more saturates
  assign wide_hi = WIDE_W'(in_rec.num) >> Q_W;

  always_ff @(posedge clk) begin
    stg[0].status <= in_rec.status;
    stg[0].pass   <= (in_rec.status != ST_COLLIDE) || (in_rec.den == '0);
    stg[0].sat    <= wide_hi >= WIDE_W'(in_rec.den);
    stg[0].rem    <= wide_hi[DEN_W-1:0];
    stg[0].den    <= in_rec.den;
    stg[0].numlo  <= in_rec.num[Q_W-1:0];
    stg[0].q      <= '0;
    stg[0].ux     <= in_rec.ux;
    stg[0].uy     <= in_rec.uy;
    stg[0].w      <= in_rec.w;
    stg[0].nx     <= in_rec.nx;
    stg[0].ny     <= in_rec.ny;
    stg[0].pdn    <= in_rec.pdn;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_bit
    logic [DEN_W:0] r, sub;
    logic           ge;
    dstage_t        stg_next;

    always_comb begin
      r   = {stg[k-1].rem, stg[k-1].numlo[Q_W-k]};
      sub = r - {1'b0, stg[k-1].den};
      ge  = r >= {1'b0, stg[k-1].den};
      stg_next          = stg[k-1];
      stg_next.rem      = ge ? sub[DEN_W-1:0] : r[DEN_W-1:0];
      stg_next.q[Q_W-k] = ge;
    end

    always_ff @(posedge clk) begin
      stg[k] <= stg_next;
    end
  end

  assign out_valid      = vld[Q_W];
  assign out_imp.status = stg[Q_W].status;
  assign out_imp.pass   = stg[Q_W].pass;
  assign out_imp.j      = stg[Q_W].sat ? {Q_W{1'b1}} : stg[Q_W].q;
  assign out_imp.ux     = stg[Q_W].ux;
  assign out_imp.uy     = stg[Q_W].uy;
  assign out_imp.w      = stg[Q_W].w;
  assign out_imp.nx     = stg[Q_W].nx;
  assign out_imp.ny     = stg[Q_W].ny;
  assign out_imp.pdn    = stg[Q_W].pdn;

endmodule

// ----- rtl/bwci_back.sv -----
// back end: scales the impulse and updates the velocities
module bwci_back import bwci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  imp_t               in_imp,
  input  cfg_t               cfg,
  output logic               done,
  output logic [1:0]         contact_status,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_ang_vel
);

  logic        b1_valid, b2_valid;
  logic [61:0] b1_jm, b1_ji;
  imp_t        b1, b2;
  logic [30:0] jm, ji;
  logic signed [49:0] b2_pmx, b2_pmy;
  logic signed [63:0] b2_pw;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= in_valid;
      b2_valid <= b1_valid;
      done     <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_jm <= 62'(in_imp.j) * 62'(cfg.inv_mass);
    b1_ji <= 62'(in_imp.j) * 62'(cfg.inv_inertia);
    b1    <= in_imp;
  end

  assign jm = usat31(64'(b1_jm >> FRAC_BITS));
  assign ji = usat31(64'(b1_ji >> FRAC_BITS));

  always_ff @(posedge clk) begin
    b2_pmx <= $signed({1'b0, jm}) * b1.nx;
    b2_pmy <= $signed({1'b0, jm}) * b1.ny;
    b2_pw  <= $signed({1'b0, ji}) * b1.pdn;
    b2     <= b1;
  end

  always_ff @(posedge clk) begin
    contact_status <= b2.status;
    if (b2.pass) begin
      new_vel_x   <= b2.ux;
      new_vel_y   <= b2.uy;
      new_ang_vel <= b2.w;
    end else begin
      new_vel_x   <= sat32(66'(b2.ux) + 66'(b2_pmx >>> FRAC_BITS));
      new_vel_y   <= sat32(66'(b2.uy) + 66'(b2_pmy >>> FRAC_BITS));
      new_ang_vel <= sat32(66'(b2.w) + 66'(b2_pw >>> FRAC_BITS));
    end
  end

endmodule

// ----- rtl/body_wall_contact_impulse_unit.sv -----
// top level of the vertex against wall contact impulse unit
//
//  channel   signals                                 handshake
//  input     start, busy, vertex..wall_offset        taken when start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, data   written when valid && ready
//  result    done, contact_status, new_vel_*         one cycle strobe on done
//
// one pair per cycle sustained while busy is low
// start to done runs through classification, the queue, the divider and the update
// the divider's bit stages are the longest part; busy rises only if the queue backs up
// rst is synchronous and restores the registers to one unit each
// results cannot be held off, so the back end drains the queue every cycle
module body_wall_contact_impulse_unit import bwci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] ang_vel,
  input  logic signed [17:0] wall_normal_x,
  input  logic signed [17:0] wall_normal_y,
  input  logic signed [31:0] wall_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [1:0]         contact_status,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_ang_vel
);

  cfg_t            cfg;
  logic            accept;
  logic            front_valid, q_pop, div_valid;
  work_t           front_rec, q_rec;
  imp_t            div_imp;
  logic [QPTR_W:0] q_count;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  // keep room for everything still in the front pipeline
  assign busy      = q_count >= (QPTR_W+1)'(QUEUE_DEPTH - FRONT_LAT - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_mass    <= 31'(1 << FRAC_BITS);
      cfg.inv_inertia <= 31'(1 << FRAC_BITS);
      cfg.restitution <= 17'(1 << FRAC_BITS);
      cfg.depth_eps   <= 31'(1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_INV_MASS:    cfg.inv_mass    <= cfg_data[30:0];
        REG_INV_INERTIA: cfg.inv_inertia <= cfg_data[30:0];
        REG_RESTITUTION: cfg.restitution <= cfg_data[16:0];
        REG_DEPTH_EPS:   cfg.depth_eps   <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  bwci_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .center_x      (center_x),
    .center_y      (center_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .ang_vel       (ang_vel),
    .wall_normal_x (wall_normal_x),
    .wall_normal_y (wall_normal_y),
    .wall_offset   (wall_offset),
    .cfg           (cfg),
    .out_valid     (front_valid),
    .out_rec       (front_rec)
  );

  bwci_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .push_rec (front_rec),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .count    (q_count)
  );

  bwci_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_pop),
    .in_rec    (q_rec),
    .out_valid (div_valid),
    .out_imp   (div_imp)
  );

  bwci_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (div_valid),
    .in_imp         (div_imp),
    .cfg            (cfg),
    .done           (done),
    .contact_status (contact_status),
    .new_vel_x      (new_vel_x),
    .new_vel_y      (new_vel_y),
    .new_ang_vel    (new_ang_vel)
  );

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the vertex against wall contact impulse unit
`timescale 1ns / 1ps

module testbench;
  import bwci_pkg::*;

  typedef struct {
    logic signed [31:0] vx, vy, cx, cy, ux, uy, w;
    logic signed [17:0] nx, ny;
    logic signed [31:0] c;
  } pair_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] vel_x, vel_y, ang;
  } response_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [31:0] vertex_x = 0, vertex_y = 0, center_x = 0, center_y = 0;
  logic signed [31:0] vel_x = 0, vel_y = 0, ang_vel = 0, wall_offset = 0;
  logic signed [17:0] wall_normal_x = 0, wall_normal_y = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_INV_MASS;
  logic [31:0] cfg_data = 0;
  logic done;
  logic [1:0] contact_status;
  logic signed [31:0] new_vel_x, new_vel_y, new_ang_vel;

  body_wall_contact_impulse_unit u_dut (.*);

  cfg_t      body_cfg;
  pair_t     pending_pairs[$];
  response_t expected_responses[$];
  pair_t     on_ports;
  int        errors = 0;
  int        send_idle_pct = 10;
  int        quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint sat_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint usat_q(longint x);
    return (x > 64'sd2147483647) ? 64'sd2147483647 : x;
  endfunction

  // impulse response of one pair under the current body settings
  function automatic response_t pair_response(pair_t p);
    response_t r;
    longint eps, distance, rx, ry, pdn, vn2, vn, onepe, num, sq, den, j, jm, ji;
    eps = longint'(body_cfg.depth_eps) <<< FRAC_BITS;
    distance = longint'(p.vx) * p.nx + longint'(p.vy) * p.ny + (longint'(p.c) <<< FRAC_BITS);
    rx = longint'(p.vx) - p.cx;
    ry = longint'(p.vy) - p.cy;
    pdn = sat_q((rx * p.ny - ry * p.nx) >>> FRAC_BITS);
    vn2 = longint'(p.ux) * p.nx + longint'(p.uy) * p.ny + longint'(p.w) * pdn;
    r.status = ST_CLEAR;
    r.vel_x = p.ux;
    r.vel_y = p.uy;
    r.ang = p.w;
    if (distance < -eps) begin
      r.status = ST_PENETRATE;
    end else if (distance < eps && vn2 < 0) begin
      r.status = ST_COLLIDE;
      vn = sat_q(vn2 >>> FRAC_BITS);
      onepe = (64'sd1 <<< FRAC_BITS) + body_cfg.restitution;
      num = onepe * (-vn);
      sq = usat_q((pdn * pdn) >>> FRAC_BITS);
      den = longint'(body_cfg.inv_mass) + ((longint'(body_cfg.inv_inertia) * sq) >>> FRAC_BITS);
      if (den != 0) begin
        j = usat_q(num / den);
        jm = usat_q((j * body_cfg.inv_mass) >>> FRAC_BITS);
        ji = usat_q((j * body_cfg.inv_inertia) >>> FRAC_BITS);
        r.vel_x = 32'(sat_q(p.ux + ((jm * p.nx) >>> FRAC_BITS)));
        r.vel_y = 32'(sat_q(p.uy + ((jm * p.ny) >>> FRAC_BITS)));
        r.ang = 32'(sat_q(p.w + ((ji * pdn) >>> FRAC_BITS)));
      end
    end
    return r;
  endfunction

  function automatic logic signed [17:0] pick_normal();
    case ($urandom_range(0, 7))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'sd46341;
      3: return -18'sd46341;
      4: return 18'sd0;
      5: return 18'($urandom);
      default: return 18'($urandom_range(0, 131072)) - 18'sd65536;
    endcase
  endfunction

  // mostly pairs near the wall with bounded magnitudes, some fully random bits
  function automatic pair_t random_pair();
    pair_t p;
    longint proj;
    p.nx = pick_normal();
    p.ny = pick_normal();
    if ($urandom_range(0, 99) < 25) begin
      p.vx = $urandom; p.vy = $urandom; p.cx = $urandom; p.cy = $urandom;
      p.ux = $urandom; p.uy = $urandom; p.w = $urandom; p.c = $urandom;
    end else begin
      p.vx = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      p.vy = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      p.cx = p.vx + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      p.cy = p.vy + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      p.ux = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      p.uy = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      p.w = int'($urandom_range(0, 1 << 18)) - (1 << 17);
      proj = (longint'(p.vx) * p.nx + longint'(p.vy) * p.ny) >>> FRAC_BITS;
      p.c = 32'(-proj + int'($urandom_range(0, 1 << 18)) - (1 << 17));
    end
    return p;
  endfunction

  function automatic pair_t make_pair(int vx, vy, cx, cy, ux, uy, w,
                                      logic signed [17:0] nx, ny, int c);
    pair_t p;
    p.vx = vx; p.vy = vy; p.cx = cx; p.cy = cy;
    p.ux = ux; p.uy = uy; p.w = w; p.nx = nx; p.ny = ny; p.c = c;
    return p;
  endfunction

  // input driver
  always @(posedge clk) begin
    pair_t nxt;
    logic next_start;
    next_start = start;
    if (rst) begin
      next_start = 0;
    end else begin
      if (start && !busy) begin
        expected_responses.push_back(pair_response(on_ports));
        next_start = 0;
      end
      if (!(start && busy) && pending_pairs.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_pairs.pop_front();
        on_ports <= nxt;
        vertex_x <= nxt.vx; vertex_y <= nxt.vy;
        center_x <= nxt.cx; center_y <= nxt.cy;
        vel_x <= nxt.ux; vel_y <= nxt.uy; ang_vel <= nxt.w;
        wall_normal_x <= nxt.nx; wall_normal_y <= nxt.ny;
        wall_offset <= nxt.c;
        next_start = 1;
      end
    end
    start <= next_start;
  end

  // result monitor
  always @(posedge clk) begin
    response_t e;
    if (!rst && done) begin
      if (expected_responses.size() == 0) begin
        $error("result with no pending item");
        errors++;
      end else begin
        e = expected_responses.pop_front();
        if (contact_status !== e.status) begin
          $error("contact_status expected %0d actual %0d", e.status, contact_status);
          errors++;
        end
        if (new_vel_x !== e.vel_x) begin
          $error("new_vel_x expected %0d actual %0d", e.vel_x, new_vel_x);
          errors++;
        end
        if (new_vel_y !== e.vel_y) begin
          $error("new_vel_y expected %0d actual %0d", e.vel_y, new_vel_y);
          errors++;
        end
        if (new_ang_vel !== e.ang) begin
          $error("new_ang_vel expected %0d actual %0d", e.ang, new_ang_vel);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || start || expected_responses.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INV_MASS:    body_cfg.inv_mass = value[30:0];
      REG_INV_INERTIA: body_cfg.inv_inertia = value[30:0];
      REG_RESTITUTION: body_cfg.restitution = value[16:0];
      default:         body_cfg.depth_eps = value[30:0];
    endcase
    cfg_valid <= 0;
  endtask

  task automatic set_body(logic [31:0] m, logic [31:0] i, logic [31:0] e, logic [31:0] d);
    wait_drained();
    write_reg(REG_INV_MASS, m);
    write_reg(REG_INV_INERTIA, i);
    write_reg(REG_RESTITUTION, e);
    write_reg(REG_DEPTH_EPS, d);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    body_cfg.inv_mass = 65536;
    body_cfg.inv_inertia = 65536;
    body_cfg.restitution = 65536;
    body_cfg.depth_eps = 65536;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extremes, clear, penetrating, colliding
    pending_pairs.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'sh1ffff, 18'sh1ffff, 32'h7fffffff));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
      32'h80000000, 32'h80000000, 32'h80000000, -18'sh20000, -18'sh20000, 32'h80000000));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -65536, 0, 0, 65536, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 65536, 0, 0, 65536, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 65536, -5 * 65536));
    pending_pairs.push_back(make_pair(0, 65536, 65536, 0, 0, -131072, 65536, 0, 65536, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 32'h80000000, 32'h80000000, 0,
      65536, 65536, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(65536, 0, 0, 0, 0, -65536, 32'h80000000,
      -65536, 65536, 65536));
    queue_random(330);

    // zero mass and inertia response: zero denominator, no bounce, exact contact
    set_body(0, 0, 0, 0);
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -65536, 0, 0, 65536, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -65536, 0, 0, 65536, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -65536, 0, 0, 65536, 0, -1));
    queue_random(200);
    set_body(0, 32'h7fffffff, 0, 0);
    queue_random(120);

    send_idle_pct = 64;
    set_body(32'h7fffffff, 0, 32'h1ffff, 32'h7fffffff);
    queue_random(220);
    set_body(32'h7fffffff, 32'h7fffffff, 65536, 32'h7fffffff);
    queue_random(120);

    send_idle_pct = 0;
    repeat (4) begin
      set_body($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18),
               $urandom_range(0, 65536), $urandom_range(0, 1 << 20));
      queue_random(100);
    end

    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
